// ===== hdl/gdt_pkg.sv =====
// Shared types, constants and codes of the grid ray traversal core.
// Used by the top level, gdt_ctrl and gdt_dp; depends on nothing.
package gdt_pkg;

  localparam int MAP_SIDE_DEF = 64;
  localparam int FRAC_BITS    = 8;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int LIMIT        = 100 << FRAC_BITS;
  localparam int DIST_CAP     = 1 << (10 + FRAC_BITS);

  localparam int ROOT_W     = 48;
  localparam int ROOT_ITERS = 24;
  localparam int MAG_W      = 24;
  localparam int DIV_NW     = 42;
  localparam int LEN_W      = 27;
  localparam int CELL_W     = 9;
  localparam int CNT_W      = 5;

  localparam logic       OP_WRITE       = 1'b0;
  localparam logic       OP_CAST        = 1'b1;
  localparam logic [0:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [5:0]         tile_col;
    logic [5:0]         tile_row;
    logic               tile_solid;
    logic [7:0]         tile_texture;
    logic [13:0]        origin_x;
    logic [13:0]        origin_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [14:0] hit_distance;
    logic [7:0]  hit_texture;
    logic [7:0]  wall_slice;
    logic        x_side;
  } res_item_t;

  typedef enum logic [1:0] {
    DIV_X,
    DIV_Y,
    DIV_HIT
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQ,
    ST_ROOT_LD,
    ST_ROOT,
    ST_DX_GO,
    ST_DX_WAIT,
    ST_DY_GO,
    ST_DY_WAIT,
    ST_INIT,
    ST_WALK,
    ST_HMUL,
    ST_HD_GO,
    ST_HD_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic     clr_en;
    logic     tile_wr;
    logic     ray_ld;
    logic     sq_en;
    logic     root_ld;
    logic     root_en;
    logic     div_go;
    div_sel_e div_sel;
    logic     cap_x;
    logic     cap_y;
    logic     walk_init;
    logic     walk_en;
    logic     hit_cap;
    logic     hmul_en;
    logic     fin_en;
  } gdt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dir_zero;
    logic div_done;
    logic hit_now;
    logic dist_done;
  } gdt_stat_t;

endpackage

// ===== hdl/grid_ray_dda_traversal_core.sv =====
// Top level of the grid ray traversal core: configuration registers and the
// controller and datapath. Depends on gdt_pkg, gdt_ctrl and gdt_dp.
//
// The block keeps a MAP_SIDE x MAP_SIDE tile map and casts rays through it.
// A command is taken at a rising edge where start_i is high and busy_o is low.
// A tile write command stores one tile in that same cycle and gives no result;
// the block stays free, so writes can be issued back to back.
// A ray command keeps busy_o high while the ray is processed: setup (the
// squares, the root load, a 24-step square root, two step length divisions
// and seeding the walk), then the walk of one grid cell per cycle, bounded by
// the 100-cell distance limit, then the hit point multiply and division when a
// wall is met, and at last the result is formatted. A ray with a zero
// direction goes from the squares straight to the result formatting.
// Each ray gives one result transfer on res_o, marked by done_o for exactly
// one cycle, the cycle in which busy_o has just fallen; the receiver has no
// way to stall it and must take it then.
// The configuration channel (cfg_valid_i/cfg_ready_o) is always ready and
// should only be written while the block is idle.
// After reset the map is cleared by a pass over all MAP_SIDE*MAP_SIDE tiles,
// one per cycle; busy_o stays high meanwhile.
module grid_ray_dda_traversal_core
  import gdt_pkg::*;
#(
  parameter int MAP_SIDE = MAP_SIDE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  in_item_t   cmd_i,
  output logic       busy_o,
  output logic       done_o,
  output res_item_t  res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  logic [6:0] map_width_q, map_height_q;
  gdt_cmd_t   ctl;
  gdt_stat_t  stat;

  // The configuration registers accept a transfer in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= 7'd64;
      map_height_q <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  gdt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (cmd_i.operation),
    .stat_i (stat),
    .cmd_o  (ctl),
    .busy_o (busy_o)
  );

  gdt_dp #(
    .MAP_SIDE(MAP_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctl),
    .item_i      (cmd_i),
    .map_width_i (map_width_q),
    .map_height_i(map_height_q),
    .stat_o      (stat),
    .res_o       (res_o),
    .done_o      (done_o)
  );

`ifndef SYNTHESIS
  // A ray takes many cycles, so two results never come back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // An accepted ray makes the block busy in the next cycle.
  a_ray_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i.operation == OP_CAST) |=> busy_o)
    else $error("ray accepted without going busy");

  // A miss reports all other fields as zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.hit) |-> (res_o.hit_distance == 15'd0 &&
      res_o.hit_texture == 8'd0 && res_o.wall_slice == 8'd0 && !res_o.x_side))
    else $error("miss result carries nonzero fields");

  // A result is only produced while a ray was in work.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a ray in work");
`endif

endmodule

// ===== hdl/gdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gdt_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/gdt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by all divisions of the core.
module gdt_div #(
  parameter int NW  = 42,
  parameter int DVW = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  logic [NW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic [NW-1:0]  quot_o,
  output logic           done_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]  q_q;
  logic [DVW-1:0] rem_q, dvs_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;
  logic [DVW:0]   rem_sh, rem_sub;
  logic           qbit;

  assign rem_sh  = {rem_q, q_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign qbit    = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(NW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      q_q   <= {q_q[NW-2:0], qbit};
      rem_q <= qbit ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

// ===== hdl/gdt_ctrl.sv =====
// Sequencer of the grid ray traversal core: clear pass, setup, walk, hit point.
// Depends on gdt_pkg; drives gdt_dp through command and status structs.
module gdt_ctrl
  import gdt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      op_i,
  input  gdt_stat_t stat_i,
  output gdt_cmd_t  cmd_o,
  output logic      busy_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_X;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_CAST) begin
            cmd_o.ray_ld = 1'b1;
            state_d = ST_SQ;
          end else begin
            cmd_o.tile_wr = 1'b1;
          end
        end
      end
      ST_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d = stat_i.dir_zero ? ST_FIN : ST_ROOT_LD;
      end
      ST_ROOT_LD: begin
        cmd_o.root_ld = 1'b1;
        cnt_d   = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_en = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROOT_ITERS - 1)) begin
          state_d = ST_DX_GO;
        end
      end
      ST_DX_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_X;
        state_d = ST_DX_WAIT;
      end
      ST_DX_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.cap_x = 1'b1;
          state_d = ST_DY_GO;
        end
      end
      ST_DY_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_Y;
        state_d = ST_DY_WAIT;
      end
      ST_DY_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.cap_y = 1'b1;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (stat_i.hit_now) begin
          cmd_o.hit_cap = 1'b1;
          state_d = ST_HMUL;
        end else if (stat_i.dist_done) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.walk_en = 1'b1;
        end
      end
      ST_HMUL: begin
        cmd_o.hmul_en = 1'b1;
        state_d = ST_HD_GO;
      end
      ST_HD_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_HIT;
        state_d = ST_HD_WAIT;
      end
      ST_HD_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin_en = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/gdt_dp.sv =====
// Datapath of the grid ray traversal core: tile RAM, square root, divider use,
// DDA walk registers and result formatting. Depends on gdt_pkg, gdt_ram, gdt_div.
module gdt_dp
  import gdt_pkg::*;
#(
  parameter int MAP_SIDE = MAP_SIDE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  gdt_cmd_t   cmd_i,
  input  in_item_t   item_i,
  input  logic [6:0] map_width_i,
  input  logic [6:0] map_height_i,
  output gdt_stat_t  stat_o,
  output res_item_t  res_o,
  output logic       done_o
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + CELL_W;

  // Tile RAM and clearing pass.
  logic [AW-1:0] clr_q, waddr, raddr;
  logic          we;
  logic [8:0]    wdata, rdata;
  logic [PW-1:0] wfull, rfull;
  logic          wr_in_map;

  assign wr_in_map = (CELL_W'(item_i.tile_col) < CELL_W'(MAP_SIDE)) &&
                     (CELL_W'(item_i.tile_row) < CELL_W'(MAP_SIDE));
  assign wfull = PW'(item_i.tile_row) * PW'(MAP_SIDE) + PW'(item_i.tile_col);
  assign we    = cmd_i.clr_en || (cmd_i.tile_wr && wr_in_map);
  assign waddr = cmd_i.clr_en ? clr_q : wfull[AW-1:0];
  assign wdata = cmd_i.clr_en ? 9'd0 : {item_i.tile_solid, item_i.tile_texture};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  gdt_ram #(
    .WIDTH(9),
    .DEPTH(DEPTH)
  ) u_tiles (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Ray registers.
  logic [13:0] ox_q, oy_q;
  logic        xneg_q, yneg_q;
  logic [15:0] ax_q, ay_q;
  logic [16:0] dxe, dye, dxn, dyn;

  assign dxe = {item_i.dir_x[15], item_i.dir_x};
  assign dye = {item_i.dir_y[15], item_i.dir_y};
  assign dxn = 17'd0 - dxe;
  assign dyn = 17'd0 - dye;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ray_ld) begin
      ox_q   <= item_i.origin_x;
      oy_q   <= item_i.origin_y;
      xneg_q <= dxe[16];
      yneg_q <= dye[16];
      ax_q   <= dxe[16] ? dxn[15:0] : dxe[15:0];
      ay_q   <= dye[16] ? dyn[15:0] : dye[15:0];
    end
  end

  // Squares and bit-pair square root of (ax^2 + ay^2) << 16.
  logic [31:0]       sqx_q, sqy_q, sqsum;
  logic [ROOT_W-1:0] v_q, r_q, b_q, rb;
  logic [MAG_W-1:0]  mag;

  assign sqsum = sqx_q + sqy_q;
  assign rb    = r_q + b_q;
  assign mag   = r_q[MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sqx_q <= 32'(ax_q) * 32'(ax_q);
      sqy_q <= 32'(ay_q) * 32'(ay_q);
    end
    if (cmd_i.root_ld) begin
      v_q <= {sqsum, 16'd0};
      r_q <= '0;
      b_q <= ROOT_W'(1) << 46;
    end else if (cmd_i.root_en) begin
      if (v_q >= rb) begin
        v_q <= v_q - rb;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  // Shared divider.
  logic [DIV_NW-1:0] div_n, quot;
  logic [MAG_W-1:0]  div_v;
  logic              div_done;
  logic [33:0]       prod_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_X: begin
        div_n = DIV_NW'(mag);
        div_v = MAG_W'(ax_q);
      end
      DIV_Y: begin
        div_n = DIV_NW'(mag);
        div_v = MAG_W'(ay_q);
      end
      DIV_HIT: begin
        div_n = {prod_q, 8'd0};
        div_v = mag;
      end
      default: begin
        div_n = '0;
        div_v = mag;
      end
    endcase
  end

  gdt_div #(
    .NW (DIV_NW),
    .DVW(MAG_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (cmd_i.div_go),
    .dividend_i(div_n),
    .divisor_i (div_v),
    .quot_o    (quot),
    .done_o    (div_done)
  );

  // Step lengths. A zero axis never steps, which the infinity flags carry.
  logic [MAG_W-1:0] delx_q, dely_q;
  logic             xinf, yinf;

  assign xinf = (ax_q == 16'd0);
  assign yinf = (ay_q == 16'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_x) begin
      delx_q <= quot[MAG_W-1:0];
    end
    if (cmd_i.cap_y) begin
      dely_q <= quot[MAG_W-1:0];
    end
  end

  // DDA walk.
  logic [LEN_W-1:0]         lx_q, ly_q, dist_q;
  logic signed [CELL_W-1:0] cx_q, cy_q, cx_d, cy_d;
  logic                     xside_q, vld_q, xs, inb, hit_q;
  logic [8:0]               fsx, fsy, ew, eh;
  logic [32:0]              lx0, ly0;
  logic [7:0]               tex_q;

  assign fsx = xneg_q ? {1'b0, ox_q[7:0]} : 9'(ONE) - {1'b0, ox_q[7:0]};
  assign fsy = yneg_q ? {1'b0, oy_q[7:0]} : 9'(ONE) - {1'b0, oy_q[7:0]};
  assign lx0 = 33'(fsx) * 33'(delx_q);
  assign ly0 = 33'(fsy) * 33'(dely_q);
  assign xs  = xinf ? 1'b0 : (yinf ? 1'b1 : (lx_q < ly_q));

  assign ew = (9'(map_width_i) > 9'(MAP_SIDE)) ? 9'(MAP_SIDE) : 9'(map_width_i);
  assign eh = (9'(map_height_i) > 9'(MAP_SIDE)) ? 9'(MAP_SIDE) : 9'(map_height_i);
  assign inb = !cx_q[CELL_W-1] && !cy_q[CELL_W-1] &&
               (9'(cx_q) < ew) && (9'(cy_q) < eh);

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    if (xs) begin
      cx_d = cx_q + (xneg_q ? -9'sd1 : 9'sd1);
    end else begin
      cy_d = cy_q + (yneg_q ? -9'sd1 : 9'sd1);
    end
  end

  // The read address is the cell that this step enters, so its tile is
  // ready in the cycle after the step.
  assign rfull = PW'(cy_d[CELL_W-2:0]) * PW'(MAP_SIDE) + PW'(cx_d[CELL_W-2:0]);
  assign raddr = rfull[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      lx_q    <= LEN_W'(lx0[32:FRAC_BITS]);
      ly_q    <= LEN_W'(ly0[32:FRAC_BITS]);
      cx_q    <= CELL_W'(ox_q[13:FRAC_BITS]);
      cy_q    <= CELL_W'(oy_q[13:FRAC_BITS]);
      dist_q  <= '0;
      xside_q <= 1'b0;
    end else if (cmd_i.walk_en) begin
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      xside_q <= xs;
      if (xs) begin
        dist_q <= lx_q;
        lx_q   <= lx_q + LEN_W'(delx_q);
      end else begin
        dist_q <= ly_q;
        ly_q   <= ly_q + LEN_W'(dely_q);
      end
    end
    if (cmd_i.hit_cap) begin
      tex_q <= rdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      if (cmd_i.walk_init) begin
        vld_q <= 1'b0;
      end else if (cmd_i.walk_en) begin
        vld_q <= 1'b1;
      end
      if (cmd_i.ray_ld) begin
        hit_q <= 1'b0;
      end else if (cmd_i.hit_cap) begin
        hit_q <= 1'b1;
      end
    end
  end

  // Hit point: offset along the face = dc * a * ONE / mag, where mag is |d| * ONE.
  logic [18:0] dc;
  logic [15:0] asel;

  assign dc   = (dist_q > LEN_W'(DIST_CAP)) ? 19'(DIST_CAP) : dist_q[18:0];
  assign asel = xside_q ? ay_q : ax_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hmul_en) begin
      prod_q <= 34'(dc) * 34'(asel);
    end
  end

  // Result formatting.
  logic [7:0] obase, fr;
  logic       oneg, inv;
  logic [8:0] slice;
  res_item_t  res_hit;
  res_item_t  res_q;
  logic       done_q;

  assign obase = xside_q ? oy_q[7:0] : ox_q[7:0];
  assign oneg  = xside_q ? yneg_q : xneg_q;
  assign fr    = oneg ? (obase - quot[7:0]) : (obase + quot[7:0]);
  assign inv   = xside_q ? xneg_q : !yneg_q;
  assign slice = inv ? (9'(ONE) - {1'b0, fr}) : {1'b0, fr};

  always_comb begin
    res_hit              = '0;
    res_hit.hit          = 1'b1;
    res_hit.hit_distance = (dist_q > LEN_W'(32767)) ? 15'h7FFF : dist_q[14:0];
    res_hit.hit_texture  = tex_q;
    res_hit.wall_slice   = slice[8] ? 8'hFF : slice[7:0];
    res_hit.x_side       = xside_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_en) begin
      res_q <= hit_q ? res_hit : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.fin_en;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

  assign stat_o.clr_last  = (clr_q == AW'(DEPTH - 1));
  assign stat_o.dir_zero  = xinf && yinf;
  assign stat_o.div_done  = div_done;
  assign stat_o.hit_now   = vld_q && inb && rdata[8];
  assign stat_o.dist_done = (dist_q >= LEN_W'(LIMIT));

endmodule
